>>> hdl/crt2_pkg.sv
// ----------------------------------------------------------------------------
// crt2_pkg
// beat types and fixed field widths for the two-congruence merge core
// ----------------------------------------------------------------------------
package crt2_pkg;

    localparam int FIELD_W = 32;
    localparam int RESULT_W = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] res_a;
        logic [FIELD_W-1:0] mod_n;
        logic [FIELD_W-1:0] res_b;
        logic [FIELD_W-1:0] mod_m;
    } req_beat_t;

    typedef struct packed {
        logic                solvable;
        logic [RESULT_W-1:0] solution;
        logic [RESULT_W-1:0] combined_modulus;
    } rsp_beat_t;

endpackage

>>> hdl/crt2_req_if.sv
// ----------------------------------------------------------------------------
// crt2_req_if
// request channel: two congruences per beat
// ----------------------------------------------------------------------------
interface crt2_req_if;
    logic                 valid;
    logic                 ready;
    crt2_pkg::req_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/crt2_rsp_if.sv
// ----------------------------------------------------------------------------
// crt2_rsp_if
// response channel: merged congruence per beat
// ----------------------------------------------------------------------------
interface crt2_rsp_if;
    logic                 valid;
    logic                 ready;
    crt2_pkg::rsp_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/crt_two_congruence_merge_core.sv
// ----------------------------------------------------------------------------
// crt_two_congruence_merge_core
// merges x = res_a mod mod_n and x = res_b mod mod_m into x mod lcm
// ----------------------------------------------------------------------------
// req carries one beat of two congruences; rsp returns one beat per request
// with solvable, the smallest non-negative solution and lcm(mod_n, mod_m),
// both zero when the pair is inconsistent or a modulus is zero.
// inputs are reduced to their low MOD_WIDTH bits.
// one request is worked at a time: req.ready is high only while idle.
// a shared restoring divider runs the residue reductions, every extended
// euclid step and the final reductions; a shift-add multiplier forms the
// three products. a zero modulus skips both units and goes straight to the
// final state.
// the result sits in an output register; the next request is taken as soon
// as it is loaded, and a stalled rsp holds the core in its final state.
// reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module crt_two_congruence_merge_core #(
    parameter int MOD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    crt2_req_if.sink   req,
    crt2_rsp_if.source rsp
);

    localparam int W = MOD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AR,
        S_BR,
        S_BRN,
        S_EUC,
        S_DG,
        S_NG,
        S_INV,
        S_MUL1,
        S_T,
        S_MUL2,
        S_MUL3,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic                wait_reg;
    logic                solv_reg;
    logic                out_valid_reg;
    crt2_pkg::rsp_beat_t out_reg;

    logic [W-1:0]        a_reg, n_reg, b_reg, m_reg;
    logic [W-1:0]        ar_reg, br_reg, diff_reg;
    logic [W-1:0]        r0_reg, r1_reg;
    logic signed [W+1:0] s0_reg, s1_reg;
    logic [W-1:0]        dq_reg, ng_reg, inv_reg, t_reg;
    logic [2*W-1:0]      p_reg, x_reg, l_reg;

    logic [W-1:0]        a_in, n_in, b_in, m_in;
    logic                is_div, is_mul, div_start, mul_start;
    logic [2*W-1:0]      div_dvd;
    logic [W-1:0]        div_dvs;
    logic signed [W+1:0] div_coef;
    logic [W-1:0]        mul_a, mul_b;
    logic signed [W+1:0] sadj;
    logic [W:0]          diff_sum;

    logic                div_busy, div_done, mul_busy, mul_done;
    logic [2*W-1:0]      div_quo, mul_prod;
    logic [W-1:0]        div_rem;
    logic signed [W+1:0] div_acc;

    assign a_in = req.data.res_a[W-1:0];
    assign n_in = req.data.mod_n[W-1:0];
    assign b_in = req.data.res_b[W-1:0];
    assign m_in = req.data.mod_m[W-1:0];

    always_comb
    begin
        sadj     = s0_reg[W+1] ? s0_reg + {2'b00, n_reg} : s0_reg;
        diff_sum = (ar_reg >= div_rem) ? {1'b0, ar_reg} - {1'b0, div_rem}
                                       : {1'b0, ar_reg} + {1'b0, n_reg} - {1'b0, div_rem};
        is_div   = 1'b0;
        is_mul   = 1'b0;
        div_dvd  = '0;
        div_dvs  = n_reg;
        div_coef = '0;
        mul_a    = m_reg;
        mul_b    = ng_reg;
        case (state_reg)
            S_AR:
            begin
                is_div  = 1'b1;
                div_dvd = {{W{1'b0}}, a_reg};
            end
            S_BR:
            begin
                is_div  = 1'b1;
                div_dvd = {{W{1'b0}}, b_reg};
                div_dvs = m_reg;
            end
            S_BRN:
            begin
                is_div  = 1'b1;
                div_dvd = {{W{1'b0}}, br_reg};
            end
            S_EUC:
            begin
                is_div   = r1_reg != '0;
                div_dvd  = {{W{1'b0}}, r0_reg};
                div_dvs  = r1_reg;
                div_coef = s1_reg;
            end
            S_DG:
            begin
                is_div  = 1'b1;
                div_dvd = {{W{1'b0}}, diff_reg};
                div_dvs = r0_reg;
            end
            S_NG:
            begin
                is_div  = 1'b1;
                div_dvd = {{W{1'b0}}, n_reg};
                div_dvs = r0_reg;
            end
            S_INV:
            begin
                is_div  = 1'b1;
                div_dvd = {{(W-1){1'b0}}, sadj[W:0]};
                div_dvs = ng_reg;
            end
            S_T:
            begin
                is_div  = 1'b1;
                div_dvd = p_reg;
                div_dvs = ng_reg;
            end
            S_MUL1:
            begin
                is_mul = 1'b1;
                mul_a  = dq_reg;
                mul_b  = inv_reg;
            end
            S_MUL2:
            begin
                is_mul = 1'b1;
                mul_b  = t_reg;
            end
            S_MUL3:
            begin
                is_mul = 1'b1;
            end
            default:
            begin
                is_div = 1'b0;
            end
        endcase
        div_start = is_div && !wait_reg;
        mul_start = is_mul && !wait_reg;
    end

    crt2_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .coef     (div_coef),
        .busy     (div_busy),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem),
        .acc      (div_acc)
    );

    crt2_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            solv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            if (div_start || mul_start)
            begin
                wait_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        a_reg <= a_in;
                        n_reg <= n_in;
                        b_reg <= b_in;
                        m_reg <= m_in;
                        x_reg <= '0;
                        l_reg <= '0;
                        if (n_in == '0 || m_in == '0)
                        begin
                            solv_reg  <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            solv_reg  <= 1'b1;
                            state_reg <= S_AR;
                        end
                    end
                end
                S_AR:
                begin
                    if (div_done)
                    begin
                        ar_reg    <= div_rem;
                        wait_reg  <= 1'b0;
                        state_reg <= S_BR;
                    end
                end
                S_BR:
                begin
                    if (div_done)
                    begin
                        br_reg    <= div_rem;
                        wait_reg  <= 1'b0;
                        state_reg <= S_BRN;
                    end
                end
                S_BRN:
                begin
                    if (div_done)
                    begin
                        diff_reg  <= diff_sum[W-1:0];
                        r0_reg    <= n_reg;
                        r1_reg    <= m_reg;
                        s0_reg    <= '0;
                        s1_reg    <= (W+2)'(1);
                        wait_reg  <= 1'b0;
                        state_reg <= S_EUC;
                    end
                end
                S_EUC:
                begin
                    if (r1_reg == '0)
                    begin
                        state_reg <= S_DG;
                    end
                    else if (div_done)
                    begin
                        r0_reg   <= r1_reg;
                        r1_reg   <= div_rem;
                        s0_reg   <= s1_reg;
                        s1_reg   <= s0_reg - div_acc;
                        wait_reg <= 1'b0;
                    end
                end
                S_DG:
                begin
                    if (div_done)
                    begin
                        dq_reg   <= div_quo[W-1:0];
                        wait_reg <= 1'b0;
                        if (div_rem != '0)
                        begin
                            solv_reg  <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_NG;
                        end
                    end
                end
                S_NG:
                begin
                    if (div_done)
                    begin
                        ng_reg    <= div_quo[W-1:0];
                        wait_reg  <= 1'b0;
                        state_reg <= S_INV;
                    end
                end
                S_INV:
                begin
                    if (div_done)
                    begin
                        inv_reg   <= div_rem;
                        wait_reg  <= 1'b0;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    if (mul_done)
                    begin
                        p_reg     <= mul_prod;
                        wait_reg  <= 1'b0;
                        state_reg <= S_T;
                    end
                end
                S_T:
                begin
                    if (div_done)
                    begin
                        t_reg     <= div_rem;
                        wait_reg  <= 1'b0;
                        state_reg <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= mul_prod + {{W{1'b0}}, br_reg};
                        wait_reg  <= 1'b0;
                        state_reg <= S_MUL3;
                    end
                end
                S_MUL3:
                begin
                    if (mul_done)
                    begin
                        l_reg     <= mul_prod;
                        wait_reg  <= 1'b0;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_reg.solvable         <= solv_reg;
                        out_reg.solution         <= solv_reg ? crt2_pkg::RESULT_W'(x_reg) : '0;
                        out_reg.combined_modulus <= solv_reg ? crt2_pkg::RESULT_W'(l_reg) : '0;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready = state_reg == S_IDLE;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    a_sol_below_lcm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.solvable |->
            rsp.data.solution < rsp.data.combined_modulus)
        else $error("solution not below combined modulus");

    a_unsolvable_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.solvable |->
            rsp.data.solution == '0 && rsp.data.combined_modulus == '0)
        else $error("unsolvable beat carries nonzero fields");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_busy && mul_busy))
        else $error("divider and multiplier running together");

    a_euclid_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EUC && div_done |=> r1_reg < r0_reg)
        else $error("euclid remainder did not shrink");

endmodule

>>> hdl/crt2_div.sv
// ----------------------------------------------------------------------------
// crt2_div
// restoring divider, one quotient bit per cycle, 2W-bit dividend by W-bit
// divisor; also accumulates quotient * coef (horner form) for extended euclid
// ----------------------------------------------------------------------------
module crt2_div #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*W-1:0]      dividend,
    input  logic [W-1:0]        divisor,
    input  logic signed [W+1:0] coef,
    output logic                busy,
    output logic                done,
    output logic [2*W-1:0]      quo,
    output logic [W-1:0]        rem,
    output logic signed [W+1:0] acc
);

    localparam int CW = $clog2(2 * W);
    localparam logic [CW-1:0] LAST = CW'(2 * W - 1);

    logic                run_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [2*W-1:0]      num_reg;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        divisor_reg;
    logic signed [W+1:0] coef_reg;
    logic signed [W+1:0] acc_reg;

    logic [W:0]          trial;
    logic                ge;
    logic [W-1:0]        rem_next;
    logic signed [W+1:0] acc_next;

    always_comb
    begin
        trial    = {rem_reg, num_reg[2*W-1]};
        ge       = trial >= {1'b0, divisor_reg};
        rem_next = ge ? W'(trial - {1'b0, divisor_reg}) : trial[W-1:0];
        acc_next = {acc_reg[W:0], 1'b0} + (ge ? coef_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            coef_reg    <= coef;
            acc_reg     <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[2*W-2:0], ge};
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;
    assign acc  = acc_reg;

endmodule

>>> hdl/crt2_mul.sv
// ----------------------------------------------------------------------------
// crt2_mul
// shift-add multiplier, one multiplier bit per cycle, W x W to 2W bits
// ----------------------------------------------------------------------------
module crt2_mul #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   op_a,
    input  logic [W-1:0]   op_b,
    output logic           busy,
    output logic           done,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic           run_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [2*W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= {{W{1'b0}}, op_a};
            mplier_reg <= op_b;
            prod_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
        end
    end

    assign busy = run_reg;
    assign done = done_reg;
    assign prod = prod_reg;

endmodule

>>> sim/crt_two_congruence_merge_core_test.sv
// ----------------------------------------------------------------------------
// crt_two_congruence_merge_core_test
// self-checking bench for the two-congruence merge core
// ----------------------------------------------------------------------------
// each request beat is predicted by an exact gcd / extended euclid solver and
// queued; every response beat is compared field by field with the oldest
// queued prediction. directed corner beats come first, then random beats
// under several source-idle and sink-stall mixes.
// ----------------------------------------------------------------------------
module crt_two_congruence_merge_core_test;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;

    crt2_req_if req ();
    crt2_rsp_if rsp ();

    crt_two_congruence_merge_core #(.MOD_WIDTH(32)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    crt2_pkg::rsp_beat_t merged_q[$];
    int        mismatch_cnt;
    int        beats_sent;
    int        beats_checked;
    int        solvable_seen;
    int        idle_pct;
    int        stall_pct;
    int        quiet_cycles;
    bit        timed_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // inverse of x mod md using signed bezout coefficients
    function automatic logic [63:0] inv_mod(logic [63:0] x, logic [63:0] md);
        longint r0, r1, s0, s1, q, rt, st;
        r0 = md;
        r1 = x % md;
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            rt = r0 - q * r1;
            st = s0 - q * s1;
            r0 = r1;
            r1 = rt;
            s0 = s1;
            s1 = st;
        end
        if (s0 < 0)
            s0 += md;
        return 64'(s0) % md;
    endfunction

    function automatic crt2_pkg::rsp_beat_t merge_congruences(crt2_pkg::req_beat_t b);
        crt2_pkg::rsp_beat_t r;
        logic [63:0] a, n, bb, m, g, ng, mg, ar, br, diff, t;
        logic [127:0] prod;
        a = b.res_a;
        n = b.mod_n;
        bb = b.res_b;
        m = b.mod_m;
        r = '0;
        if (n == 0 || m == 0)
            return r;
        g = gcd64(n, m);
        if ((a % g) != (bb % g))
            return r;
        ng = n / g;
        mg = m / g;
        ar = a % n;
        br = bb % m;
        diff = ((ar + n - (br % n)) % n) / g;
        prod = 128'(diff % ng) * 128'(inv_mod(mg, ng));
        t = 64'(prod % 128'(ng));
        r.solvable = 1'b1;
        r.solution = br + m * t;
        r.combined_modulus = m * ng;
        return r;
    endfunction

    task automatic send_beat(crt2_pkg::req_beat_t b);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        merged_q.push_back(merge_congruences(b));
        beats_sent++;
    endtask

    task automatic send_fields(logic [31:0] a, logic [31:0] n, logic [31:0] b,
                               logic [31:0] m);
        crt2_pkg::req_beat_t beat;
        beat.res_a = a;
        beat.mod_n = n;
        beat.res_b = b;
        beat.mod_m = m;
        send_beat(beat);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (merged_q.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !(stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        crt2_pkg::rsp_beat_t exp_beat;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (merged_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: %p", rsp.data);
            end
            else
            begin
                exp_beat = merged_q.pop_front();
                beats_checked++;
                if (exp_beat.solvable)
                    solvable_seen++;
                if (rsp.data.solvable !== exp_beat.solvable
                    || rsp.data.solution !== exp_beat.solution
                    || rsp.data.combined_modulus !== exp_beat.combined_modulus)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0b %0d %0d got %0b %0d %0d",
                                 exp_beat.solvable, exp_beat.solution,
                                 exp_beat.combined_modulus, rsp.data.solvable,
                                 rsp.data.solution, rsp.data.combined_modulus);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_fields(32'd2, 32'd3, 32'd3, 32'd5);
        send_fields(32'd0, 32'd1, 32'd0, 32'd1);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFB);
        send_fields(32'd5, 32'd0, 32'd1, 32'd7);
        send_fields(32'd5, 32'd7, 32'd1, 32'd0);
        send_fields(32'd0, 32'd0, 32'd0, 32'd0);
        send_fields(32'd1, 32'd4, 32'd2, 32'd6);
        send_fields(32'd3, 32'd4, 32'd5, 32'd6);
        send_fields(32'd100, 32'd7, 32'd200, 32'd11);
        send_fields(32'hFFFF_FFFF, 32'd2, 32'd0, 32'h8000_0000);
        send_fields(32'h8000_0001, 32'h8000_0000, 32'd1, 32'h4000_0000);
        send_fields(32'd7, 32'd12, 32'd7, 32'd12);
        send_fields(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
        send_fields(32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE);
        send_fields(32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(32'd13, 32'h0001_0000, 32'd9, 32'h0000_1000);
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        logic [31:0] g, n, m, a, b;
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
        begin
            case ($urandom_range(9, 0))
                0: send_fields($urandom, $urandom, $urandom, $urandom);
                1: send_fields($urandom, $urandom_range(3, 0), $urandom,
                               $urandom_range(3, 0));
                default:
                begin
                    // shared factor g (possibly 1), then b consistent with a mod g except one time in four
                    g = $urandom_range(1, 1 << $urandom_range(16, 0));
                    n = g * $urandom_range(1, 32'hFFFF_FFFF / g);
                    m = g * $urandom_range(1, 32'hFFFF_FFFF / g);
                    a = $urandom;
                    b = ($urandom_range(3, 0) == 0) ? $urandom
                        : (a % g) + g * $urandom_range(0, (32'hFFFF_FFFF - g) / g);
                    send_fields(a, n, b, m);
                end
            endcase
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 49, 0);
        test_random(300, 0, 49);
        test_random(300, 31, 31);
        stall_pct = 0;
        repeat (300) @(posedge clk);
        $display("checked %0d of %0d beats, %0d solvable, over four idle/stall mixes",
                 beats_checked, beats_sent, solvable_seen);
        if (mismatch_cnt == 0 && merged_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
